@@ rtl/core/filtered_substring_search_macros.svh @@
// Assertion helpers shared by the search block.
// Each check is sampled on clk and switched off while rst_n is low.
`ifndef FILTERED_SUBSTRING_SEARCH_MACROS_SVH
`define FILTERED_SUBSTRING_SEARCH_MACROS_SVH

// Same-cycle implication.
`define FSS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define FSS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/fss_pkg.sv @@
package fss_pkg;

  // Configuration port geometry
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CASE_INSENS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_FILTER  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CRED_TYPE    = 3'd5;

  // Pattern storage: two 64-bit registers hold 16 bytes
  localparam int PAT_REG_BYTES = 16;
  localparam int PAT_LEN_W     = 5;
  localparam int TYPE_W        = 4;
  localparam int FILTER_W      = 5;

  // Object lifecycle codes
  localparam logic [1:0] OBJ_ACTIVE = 2'd0;
  localparam logic [1:0] OBJ_SEALED = 2'd1;

  // ASCII case folding
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              first_of_object;
    logic              last_of_object;
    logic [1:0]        object_state;
    logic [TYPE_W-1:0] object_type;
  } fss_in_t;

  typedef struct packed {
    logic        matched;
    logic [31:0] payload_size;
    logic [31:0] match_total;
  } fss_out_t;

  // Per-cycle control broadcast along the cell row
  typedef struct packed {
    logic advance;
    logic fold_en;
  } fss_cell_ctrl_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c, input logic en);
    logic [7:0] res;
    res = c;
    if (en && (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      res = c + CASE_OFFSET;
    end
    return res;
  endfunction

endpackage

@@ rtl/core/fss_cell.sv @@
// One pattern position: remembers whether the pattern prefix ending at this
// position matched the stream up to the previous word.
module fss_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fss_pkg::fss_cell_ctrl_t ctrl,
  input  logic [7:0]             data_byte,
  input  logic [7:0]             pat_byte,
  input  logic                   link_in,
  output logic                   hit_nxt,
  output logic                   hit_r
);

  logic [7:0] pat_folded;

  // Extend the neighbor's prefix match by one byte
  assign pat_folded = fss_pkg::fold_char(pat_byte, ctrl.fold_en);
  assign hit_nxt    = link_in & (data_byte == pat_folded);

  // Hold the prefix bit until the next word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.advance) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

@@ rtl/core/filtered_substring_search.sv @@
// Channel | Dir | Handshake           | Word
// in      | in  | in_valid/in_ready   | fss_in_t  (one payload byte plus tags)
// out     | out | out_valid/out_ready | fss_out_t (one per object, on its last byte)
// cfg     | in  | cfg_we              | cfg_index selects, cfg_wdata carries value
//
// One byte per cycle unless in_ready is low; the result of an object's last
// byte is registered and shows on out the cycle after that byte is taken.
// The per-byte loop is the row of NCELL (MAX_PATTERN, capped at 16) prefix cells, all
// updated together in the cycle the byte is accepted.
// Bytes that do not end an object are taken even while a result waits; a
// last byte waits only while the output register is full and not drained.
// Reset (synchronous, rst_n low) clears the cells, counters, out_valid and config (type filter to all ones).
`include "filtered_substring_search_macros.svh"

module filtered_substring_search #(
  parameter int MAX_PATTERN = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fss_pkg::fss_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fss_pkg::fss_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [fss_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [fss_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int NCELL = (MAX_PATTERN < fss_pkg::PAT_REG_BYTES) ?
                         MAX_PATTERN : fss_pkg::PAT_REG_BYTES;

  // Configuration registers
  logic [fss_pkg::CFG_DATA_W-1:0] pattern_lo_r;
  logic [fss_pkg::CFG_DATA_W-1:0] pattern_hi_r;
  logic [fss_pkg::PAT_LEN_W-1:0]  pattern_len_r;
  logic                           case_insens_r;
  logic [fss_pkg::FILTER_W-1:0]   type_filter_r;
  logic [fss_pkg::TYPE_W-1:0]     cred_type_r;

  // Object state
  logic [31:0] bytes_r;
  logic [31:0] bytes_nxt;
  logic        found_r;
  logic        found_nxt;
  logic        elig_r;
  logic        elig_nxt;
  logic [31:0] total_r;
  logic [31:0] total_nxt;
  logic [31:0] total_inc;

  // Output register
  logic              out_valid_r;
  fss_pkg::fss_out_t out_data_r;

  logic                    accept;
  logic                    first;
  logic                    hit;
  logic                    obj_match;
  logic                    state_ok;
  logic                    type_ok;
  logic [7:0]              byte_folded;
  logic [2*fss_pkg::CFG_DATA_W-1:0] pat_all;
  fss_pkg::fss_cell_ctrl_t cell_ctrl;
  logic [NCELL-1:0]        cell_hit_nxt;
  logic [NCELL-1:0]        cell_hit_r;
  logic [NCELL-1:0]        cell_link;

  // Take a byte unless it would finish an object into a full, stalled output
  assign in_ready = out_ready | ~out_valid_r | ~in_data.last_of_object;
  assign accept   = in_valid & in_ready;
  assign first    = in_data.first_of_object;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_lo_r  <= '0;
      pattern_hi_r  <= '0;
      pattern_len_r <= '0;
      case_insens_r <= 1'b0;
      type_filter_r <= '1;
      cred_type_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fss_pkg::CFG_PATTERN_LOW:  pattern_lo_r  <= cfg_wdata;
        fss_pkg::CFG_PATTERN_HIGH: pattern_hi_r  <= cfg_wdata;
        fss_pkg::CFG_PATTERN_LEN:  pattern_len_r <= cfg_wdata[fss_pkg::PAT_LEN_W-1:0];
        fss_pkg::CFG_CASE_INSENS:  case_insens_r <= cfg_wdata[0];
        fss_pkg::CFG_TYPE_FILTER:  type_filter_r <= cfg_wdata[fss_pkg::FILTER_W-1:0];
        fss_pkg::CFG_CRED_TYPE:    cred_type_r   <= cfg_wdata[fss_pkg::TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  // Broadcast controls and the folded byte to the cell row
  assign pat_all           = {pattern_hi_r, pattern_lo_r};
  assign byte_folded       = fss_pkg::fold_char(in_data.data_byte, case_insens_r);
  assign cell_ctrl.advance = accept;
  assign cell_ctrl.fold_en = case_insens_r;

  genvar gi;
  generate
    for (gi = 0; gi < NCELL; gi++) begin : g_cell
      // Cell zero starts a fresh prefix; others drop history on a new object
      if (gi == 0) begin : g_head
        assign cell_link[gi] = 1'b1;
      end else begin : g_body
        assign cell_link[gi] = cell_hit_r[gi-1] & ~first;
      end

      fss_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (cell_ctrl),
        .data_byte (byte_folded),
        .pat_byte  (pat_all[8*gi +: 8]),
        .link_in   (cell_link[gi]),
        .hit_nxt   (cell_hit_nxt[gi]),
        .hit_r     (cell_hit_r[gi])
      );
    end
  endgenerate

  // Full pattern seen when the cell at the configured length fires
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NCELL; i++) begin
      if (pattern_len_r == fss_pkg::PAT_LEN_W'(i + 1)) begin
        hit = hit | cell_hit_nxt[i];
      end
    end
  end

  // Latch eligibility from the tags of the first byte
  assign state_ok = (in_data.object_state == fss_pkg::OBJ_ACTIVE) |
                    (in_data.object_state == fss_pkg::OBJ_SEALED);
  assign type_ok  = type_filter_r[fss_pkg::FILTER_W-1] |
                    (type_filter_r[fss_pkg::TYPE_W-1:0] == in_data.object_type);
  assign elig_nxt = first ? (state_ok & type_ok & (in_data.object_type != cred_type_r))
                          : elig_r;

  // Advance byte count and found flag, restarting on a new object
  assign bytes_nxt = first ? 32'd1 :
                     ((bytes_r == fss_pkg::SAT32) ? bytes_r : bytes_r + 32'd1);
  assign found_nxt = (first ? 1'b0 : found_r) | hit;
  assign obj_match = elig_nxt & found_nxt;
  assign total_inc = (total_r == fss_pkg::SAT32) ? total_r : total_r + 32'd1;
  assign total_nxt = (in_data.last_of_object & obj_match) ? total_inc : total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      found_r <= 1'b0;
      elig_r  <= 1'b0;
      total_r <= '0;
    end else if (accept) begin
      bytes_r <= bytes_nxt;
      found_r <= found_nxt;
      elig_r  <= elig_nxt;
      total_r <= total_nxt;
    end
  end

  // Load a result on the last byte; drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_data.last_of_object) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_of_object) begin
      out_data_r.matched      <= obj_match;
      out_data_r.payload_size <= bytes_nxt;
      out_data_r.match_total  <= total_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  `FSS_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_ready, !(accept && in_data.last_of_object), "result overwritten while stalled")
  `FSS_ASSERT_NEXT(a_last_gives_result, accept && in_data.last_of_object, out_valid_r, "last byte gave no result")
  `FSS_ASSERT_NOW(a_size_nonzero, out_valid_r, out_data_r.payload_size != 32'd0, "result with empty payload")
  `FSS_ASSERT_NOW(a_total_counts, out_valid_r && out_data_r.matched, out_data_r.match_total != 32'd0, "match not counted")
  `FSS_ASSERT_NEXT(a_first_restarts, accept && first, bytes_r == 32'd1, "byte count not restarted")

endmodule
